>>> sv/sam_pkg.sv
// shared types and constants for the sorted array merge block
`default_nettype none

package sam_pkg;

  // store capacities
  localparam int FIRST_DEPTH  = 32;
  localparam int SECOND_DEPTH = 32;

  // count widths hold 0 .. depth
  localparam int FIRST_CW  = $clog2(FIRST_DEPTH + 1);
  localparam int SECOND_CW = $clog2(SECOND_DEPTH + 1);

  localparam int VALUE_W = 32;

  typedef logic signed [VALUE_W-1:0] value_t;

  // vacancy marker of the first sequence
  localparam value_t VACANT = '1;

  // controls from the sequencer to both cell chains
  typedef struct packed {
    logic                 load_first;
    logic                 load_second;
    logic                 pop_first;
    logic                 pop_second;
    logic [FIRST_CW-1:0]  first_count;
    logic [SECOND_CW-1:0] second_count;
  } chain_ctrl_t;

endpackage

`default_nettype wire

>>> sv/sam_cell.sv
// one storage cell of an element chain: load from the input or take the neighbor's value
`default_nettype none

module sam_cell (
  input  wire logic            clk,
  input  wire logic            load_en,
  input  wire logic            shift_en,
  input  wire sam_pkg::value_t load_data,
  input  wire sam_pkg::value_t next_data,
  output sam_pkg::value_t      data
);
  import sam_pkg::*;

  // payload only, no reset
  always_ff @(posedge clk) begin
    if (load_en) begin
      data <= load_data;
    end else if (shift_en) begin
      data <= next_data;
    end
  end

endmodule

`default_nettype wire

>>> sv/sam_ctrl.sv
// load and merge sequencer with counts, overflow flag and output register
`default_nettype none

module sam_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // input words
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire sam_pkg::value_t      in_value,
  input  wire logic                 in_from_second,
  input  wire logic                 in_end_of_load,
  // chain heads
  input  wire sam_pkg::value_t      first_head,
  input  wire sam_pkg::value_t      second_head,
  output sam_pkg::chain_ctrl_t      ctl,
  // result words
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output sam_pkg::value_t           out_value,
  output logic                      out_last,
  output logic                      out_empty,
  output logic                      out_overflowed
);
  import sam_pkg::*;

  localparam logic ST_LOAD = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic                 state;
  logic                 state_next;
  logic [FIRST_CW-1:0]  first_count;
  logic [FIRST_CW-1:0]  first_count_next;
  logic [SECOND_CW-1:0] second_count;
  logic [SECOND_CW-1:0] second_count_next;
  logic                 overflow_seen;
  logic                 overflow_seen_next;

  logic accept;
  logic keep_first;
  logic first_full;
  logic second_full;
  logic load_first;
  logic load_second;
  logic ovf_set;
  logic step;
  logic first_any;
  logic second_any;
  logic take_first;
  logic pop_first;
  logic pop_second;
  logic done_run;

  // load side
  assign s_axis_tready = (state == ST_LOAD);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign keep_first    = !in_from_second && (in_value != VACANT);
  assign first_full    = (first_count == FIRST_CW'(FIRST_DEPTH));
  assign second_full   = (second_count == SECOND_CW'(SECOND_DEPTH));
  assign load_first    = accept && keep_first && !first_full;
  assign load_second   = accept && in_from_second && !second_full;
  assign ovf_set       = accept && ((keep_first && first_full) ||
                                    (in_from_second && second_full));

  // merge side: one word per step, ties go to the first sequence
  assign step       = (state == ST_EMIT) && (!m_axis_tvalid || m_axis_tready);
  assign first_any  = (first_count != '0);
  assign second_any = (second_count != '0);
  assign take_first = first_any && (!second_any || (first_head <= second_head));
  assign pop_first  = step && take_first;
  assign pop_second = step && !take_first && second_any;
  // at most one element left means this word ends the run
  assign done_run   = step && ((FIRST_CW + 1)'(first_count) +
                               (FIRST_CW + 1)'(second_count) <= (FIRST_CW + 1)'(1));

  // next state of counts, flag and sequencer
  always_comb begin
    first_count_next   = first_count;
    second_count_next  = second_count;
    overflow_seen_next = overflow_seen;
    state_next         = state;
    if (load_first) begin
      first_count_next = first_count + FIRST_CW'(1);
    end
    if (load_second) begin
      second_count_next = second_count + SECOND_CW'(1);
    end
    if (ovf_set) begin
      overflow_seen_next = 1'b1;
    end
    if (pop_first) begin
      first_count_next = first_count - FIRST_CW'(1);
    end
    if (pop_second) begin
      second_count_next = second_count - SECOND_CW'(1);
    end
    if (accept && in_end_of_load) begin
      state_next = ST_EMIT;
    end
    if (done_run) begin
      first_count_next   = '0;
      second_count_next  = '0;
      overflow_seen_next = 1'b0;
      state_next         = ST_LOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      first_count   <= '0;
      second_count  <= '0;
      overflow_seen <= 1'b0;
    end else begin
      state         <= state_next;
      first_count   <= first_count_next;
      second_count  <= second_count_next;
      overflow_seen <= overflow_seen_next;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (step) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (step) begin
      out_value      <= take_first ? first_head : (second_any ? second_head : '0);
      out_last       <= done_run;
      out_empty      <= !first_any && !second_any;
      out_overflowed <= overflow_seen;
    end
  end

  // chain controls
  always_comb begin
    ctl.load_first   = load_first;
    ctl.load_second  = load_second;
    ctl.pop_first    = pop_first;
    ctl.pop_second   = pop_second;
    ctl.first_count  = first_count;
    ctl.second_count = second_count;
  end

endmodule

`default_nettype wire

>>> sv/sorted_array_merge.sv
// top level: two element chains of cells and the merge sequencer
//
//  channel  | dir | tdata                  | tlast        | tuser
//  s_axis   | in  | [31:0] value           | end_of_load  | [0] from_second
//  m_axis   | out | [31:0] merged_value    | is_last      | [0] is_empty, [1] overflowed
//
// loading takes one word per cycle while no merge runs; each element goes into the cell at its store's fill count
// the word with tlast starts the merge: one result word per stored element, or one empty word
// a merge step pops the head cell of one chain and every cell of that chain takes its neighbor's value
// s_axis_tready is low while the merge runs; a full output register stalls the merge
// rst is synchronous and clears counts, overflow flag, sequencer and output valid
`default_nettype none

module sorted_array_merge (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] value
  input  wire logic        s_axis_tlast,   // end_of_load
  input  wire logic        s_axis_tuser,   // [0] from_second
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] merged_value
  output logic             m_axis_tlast,   // is_last
  output logic [1:0]       m_axis_tuser    // [0] is_empty, [1] overflowed
);
  import sam_pkg::*;

  chain_ctrl_t ctl;
  value_t      in_value;
  value_t      out_value;
  value_t      first_cells  [FIRST_DEPTH];
  value_t      second_cells [SECOND_DEPTH];
  logic        out_empty;
  logic        out_overflowed;
  logic        out_last_w;

  assign in_value = value_t'(s_axis_tdata);

  // first sequence chain, head at cell 0
  for (genvar k = 0; k < FIRST_DEPTH; k++) begin : g_first
    value_t nbr;
    if (k == FIRST_DEPTH - 1) begin : g_end
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = first_cells[k+1];
    end
    sam_cell u_cell (
      .clk       (clk),
      .load_en   (ctl.load_first && (ctl.first_count == FIRST_CW'(k))),
      .shift_en  (ctl.pop_first),
      .load_data (in_value),
      .next_data (nbr),
      .data      (first_cells[k])
    );
  end

  // second sequence chain, head at cell 0
  for (genvar k = 0; k < SECOND_DEPTH; k++) begin : g_second
    value_t nbr;
    if (k == SECOND_DEPTH - 1) begin : g_end
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = second_cells[k+1];
    end
    sam_cell u_cell (
      .clk       (clk),
      .load_en   (ctl.load_second && (ctl.second_count == SECOND_CW'(k))),
      .shift_en  (ctl.pop_second),
      .load_data (in_value),
      .next_data (nbr),
      .data      (second_cells[k])
    );
  end

  // sequencer and output register
  sam_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .in_value       (in_value),
    .in_from_second (s_axis_tuser),
    .in_end_of_load (s_axis_tlast),
    .first_head     (first_cells[0]),
    .second_head    (second_cells[0]),
    .ctl            (ctl),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .out_value      (out_value),
    .out_last       (out_last_w),
    .out_empty      (out_empty),
    .out_overflowed (out_overflowed)
  );

  assign m_axis_tdata = 32'(out_value);
  assign m_axis_tlast = out_last_w;
  assign m_axis_tuser = {out_overflowed, out_empty};

  // fill counts never pass store capacity
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (ctl.first_count <= FIRST_CW'(FIRST_DEPTH)) &&
    (ctl.second_count <= SECOND_CW'(SECOND_DEPTH)))
    else $error("fill count beyond capacity");

  // an empty word is always the last of its run
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
    else $error("empty word without last mark");

  // a chain only shifts while no words are being loaded
  a_no_pop_on_load: assert property (@(posedge clk) disable iff (rst)
    (ctl.pop_first || ctl.pop_second) |-> !s_axis_tready && !ctl.load_first && !ctl.load_second)
    else $error("merge step during load");

  // a new last word leaves both stores empty and the load side open
  a_run_clears: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) && m_axis_tlast |->
      (ctl.first_count == '0) && (ctl.second_count == '0) && s_axis_tready)
    else $error("run ended with stored elements");

endmodule

`default_nettype wire

>>> tb/sv/tb_sorted_array_merge.sv
// self-checking testbench for the sorted array merge block
`timescale 1ns / 100ps

module tb_sorted_array_merge;
  import sam_pkg::*;

  // one loaded word: element, sequence select, end of load
  typedef struct packed {
    value_t value;
    logic   second;
    logic   eol;
  } load_word_t;

  // one merged result word
  typedef struct packed {
    value_t value;
    logic   last;
    logic   empty;
    logic   ovf;
  } merged_t;

  // directed row: the word, plus a typed result where it is obvious
  typedef struct packed {
    value_t value;
    logic   second;
    logic   eol;
    logic   typed;
    value_t exp_value;
    logic   exp_empty;
    logic   exp_ovf;
  } dir_row_t;

  localparam value_t INT_MIN = 32'sh8000_0000;
  localparam value_t INT_MAX = 32'sh7fff_ffff;
  localparam int     N_ROWS  = 21;
  localparam int     N_ITEMS = 250;

  // vacancy rows, extremes, ties, unsorted input, vacancy as the closing word
  localparam dir_row_t DIR_ROWS [N_ROWS] = '{
    '{VACANT,            1'b0, 1'b1, 1'b1, 32'sd0,  1'b1, 1'b0},
    '{INT_MAX,           1'b1, 1'b1, 1'b1, INT_MAX, 1'b0, 1'b0},
    '{INT_MIN,           1'b0, 1'b1, 1'b1, INT_MIN, 1'b0, 1'b0},
    '{VACANT,            1'b1, 1'b1, 1'b1, VACANT,  1'b0, 1'b0},
    '{INT_MIN,           1'b0, 1'b0, 1'b0, 32'sd0,  1'b0, 1'b0},
    '{VACANT,            1'b0, 1'b0, 1'b0, 32'sd0,  1'b0, 1'b0},
    '{INT_MAX,           1'b0, 1'b0, 1'b0, 32'sd0,  1'b0, 1'b0},
    '{VACANT,            1'b1, 1'b0, 1'b0, 32'sd0,  1'b0, 1'b0},
    '{INT_MIN,           1'b1, 1'b0, 1'b0, 32'sd0,  1'b0, 1'b0},
    '{INT_MAX,           1'b1, 1'b1, 1'b0, 32'sd0,  1'b0, 1'b0},
    '{32'sd4,            1'b1, 1'b0, 1'b0, 32'sd0,  1'b0, 1'b0},
    '{32'sd4,            1'b0, 1'b0, 1'b0, 32'sd0,  1'b0, 1'b0},
    '{32'sd4,            1'b1, 1'b1, 1'b0, 32'sd0,  1'b0, 1'b0},
    '{32'sd10,           1'b0, 1'b0, 1'b0, 32'sd0,  1'b0, 1'b0},
    '{32'sd3,            1'b0, 1'b0, 1'b0, 32'sd0,  1'b0, 1'b0},
    '{32'sd7,            1'b1, 1'b0, 1'b0, 32'sd0,  1'b0, 1'b0},
    '{-32'sd5,           1'b1, 1'b1, 1'b0, 32'sd0,  1'b0, 1'b0},
    '{32'sd2,            1'b0, 1'b0, 1'b0, 32'sd0,  1'b0, 1'b0},
    '{VACANT,            1'b0, 1'b1, 1'b0, 32'sd0,  1'b0, 1'b0},
    '{32'sh5555_5555,    1'b0, 1'b0, 1'b0, 32'sd0,  1'b0, 1'b0},
    '{32'shaaaa_aaaa,    1'b1, 1'b1, 1'b0, 32'sd0,  1'b0, 1'b0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [31:0] value
  logic        s_axis_tlast = 1'b0; // end_of_load
  logic        s_axis_tuser = 1'b0; // [0] from_second
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [31:0] merged_value
  logic        m_axis_tlast;        // is_last
  logic [1:0]  m_axis_tuser;        // [0] is_empty, [1] overflowed

  // predictor state
  value_t  first_held[$];
  value_t  second_held[$];
  logic    ovf_seen = 1'b0;
  merged_t merge_out[$];
  merged_t merged_due[$];

  // typed result for the directed word in flight
  logic    typed_on = 1'b0;
  merged_t typed_result;

  load_word_t  load_words[$];
  int          send_idle_pct = 9;
  int          recv_idle_pct = 66;
  int unsigned mismatches = 0;

  sorted_array_merge u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // store one word and, on end of load, compute the merged run into merge_out
  function automatic void predict_merge(value_t v, logic second, logic eol);
    int      i;
    int      j;
    int      total;
    merged_t r;
    merge_out.delete();
    if (second) begin
      if (second_held.size() < SECOND_DEPTH) second_held.push_back(v);
      else ovf_seen = 1'b1;
    end else if (v != VACANT) begin
      if (first_held.size() < FIRST_DEPTH) first_held.push_back(v);
      else ovf_seen = 1'b1;
    end
    if (!eol) return;
    total = first_held.size() + second_held.size();
    if (total == 0) begin
      r = '{32'sd0, 1'b1, 1'b1, ovf_seen};
      merge_out.push_back(r);
    end else begin
      i = 0;
      j = 0;
      // two-pointer merge, ties go to the first sequence
      while (i < first_held.size() || j < second_held.size()) begin
        if (i < first_held.size() &&
            (j >= second_held.size() || first_held[i] <= second_held[j])) begin
          r.value = first_held[i];
          i++;
        end else begin
          r.value = second_held[j];
          j++;
        end
        r.last  = (merge_out.size() + 1 == total);
        r.empty = 1'b0;
        r.ovf   = ovf_seen;
        merge_out.push_back(r);
      end
    end
    first_held.delete();
    second_held.delete();
    ovf_seen = 1'b0;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] exp_v, logic [31:0] act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch in %s: expected %h, got %h", what, exp_v, act_v);
  endtask

  // predict on accepted input words, check accepted result words
  always @(posedge clk) begin
    merged_t want;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      predict_merge(s_axis_tdata, s_axis_tuser, s_axis_tlast);
      if (typed_on && s_axis_tlast) begin
        merge_out.delete();
        merge_out.push_back(typed_result);
      end
      foreach (merge_out[k]) merged_due.push_back(merge_out[k]);
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (merged_due.size() == 0) begin
        flag_mismatch("word with nothing pending", 'x, m_axis_tdata);
      end else begin
        want = merged_due.pop_front();
        if (m_axis_tdata !== want.value)
          flag_mismatch("merged_value", want.value, m_axis_tdata);
        if (m_axis_tlast !== want.last)
          flag_mismatch("is_last", 32'(want.last), 32'(m_axis_tlast));
        if (m_axis_tuser[0] !== want.empty)
          flag_mismatch("is_empty", 32'(want.empty), 32'(m_axis_tuser[0]));
        if (m_axis_tuser[1] !== want.ovf)
          flag_mismatch("overflowed", 32'(want.ovf), 32'(m_axis_tuser[1]));
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // drive one word, with random gaps before it, and wait for its handshake
  task automatic send_word(load_word_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w.value;
    s_axis_tuser  <= w.second;
    s_axis_tlast  <= w.eol;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // n values, mostly ascending from base, some loads noisy or clustered
  function automatic void ascend_fill(ref value_t q[$], input int n, input longint base,
                                      input int mode);
    longint cur;
    cur = base;
    for (int k = 0; k < n; k++) begin
      if (mode < 2) begin
        q.push_back(value_t'($urandom));
      end else if (mode == 2) begin
        q.push_back(value_t'(int'($urandom_range(0, 8)) - 4));
      end else begin
        if ($urandom_range(0, 3) != 0) cur += longint'($urandom >> $urandom_range(3, 31));
        if (cur > longint'(INT_MAX)) cur = longint'(INT_MAX);
        q.push_back(value_t'(cur));
      end
    end
  endfunction

  // one load: two interleaved sequences with stray vacancies, last word marked
  task automatic build_load(int n_first, int n_second);
    value_t     fq[$];
    value_t     sq[$];
    longint     base;
    int         mode;
    int         fi;
    int         si;
    load_word_t w;
    load_words.delete();
    mode = $urandom_range(0, 9);
    base = ($urandom_range(0, 7) == 0) ? longint'(INT_MIN) : longint'($signed($urandom));
    ascend_fill(fq, n_first, base, mode);
    ascend_fill(sq, n_second, base, mode);
    fi = 0;
    si = 0;
    while (fi < n_first || si < n_second) begin
      if ($urandom_range(0, 7) == 0) begin
        w = '{VACANT, 1'b0, 1'b0};
        load_words.push_back(w);
      end
      if (si >= n_second || (fi < n_first && $urandom_range(0, 1) == 1)) begin
        w = '{fq[fi], 1'b0, 1'b0};
        fi++;
      end else begin
        w = '{sq[si], 1'b1, 1'b0};
        si++;
      end
      load_words.push_back(w);
    end
    if (load_words.size() == 0 || $urandom_range(0, 7) == 0) begin
      w = '{VACANT, 1'b0, 1'b0};
      load_words.push_back(w);
    end
    load_words[load_words.size() - 1].eol = 1'b1;
  endtask

  // stimulus
  initial begin
    int         items;
    int         loads;
    int         n_first;
    int         n_second;
    load_word_t w;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed rows
    foreach (DIR_ROWS[r]) begin
      typed_on     = DIR_ROWS[r].typed;
      typed_result = '{DIR_ROWS[r].exp_value, 1'b1, DIR_ROWS[r].exp_empty,
                       DIR_ROWS[r].exp_ovf};
      w = '{DIR_ROWS[r].value, DIR_ROWS[r].second, DIR_ROWS[r].eol};
      send_word(w);
    end
    typed_on = 1'b0;

    // random loads, idle pattern switches as items go by
    items = 0;
    loads = 0;
    while (items < N_ITEMS) begin
      if (items >= 170) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (items >= 90) begin
        send_idle_pct = 66;
        recv_idle_pct = 9;
      end
      case (loads % 12)
        2: begin  // both stores overfull
          n_first  = $urandom_range(33, 34);
          n_second = $urandom_range(33, 34);
        end
        7: begin  // first store exactly full
          n_first  = FIRST_DEPTH;
          n_second = $urandom_range(0, 2);
        end
        default: begin
          n_first  = $urandom_range(0, 5);
          n_second = $urandom_range(0, 5);
        end
      endcase
      build_load(n_first, n_second);
      foreach (load_words[k]) send_word(load_words[k]);
      items += n_first + n_second;
      loads++;
    end
    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;

    // drain
    while (merged_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
